// ===== rtl/optical_finger_presence_detector_macros.svh =====
// ---------------------------------------------------------------------------
// optical finger presence detector assertion macros
// concurrent check wrappers, empty when SYNTH is defined
// ---------------------------------------------------------------------------
`ifndef OPTICAL_FINGER_PRESENCE_DETECTOR_MACROS_SVH
`define OPTICAL_FINGER_PRESENCE_DETECTOR_MACROS_SVH

`ifndef SYNTH

// same-cycle implication
`define OFPD_ASSERT_NOW(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("ofpd check failed");

// next-cycle implication
`define OFPD_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("ofpd check failed");

`else

`define OFPD_ASSERT_NOW(label, clk, rst, ante, cons)
`define OFPD_ASSERT_NEXT(label, clk, rst, ante, cons)

`endif

`endif

// ===== rtl/ofpd_pkg.sv =====
// ---------------------------------------------------------------------------
// ofpd_pkg
// shared widths, register indexes, reset values and ratio constants
// ---------------------------------------------------------------------------
package ofpd_pkg;

  localparam int SAMPLE_WIDTH_DEFAULT = 18;
  localparam int CFG_INDEX_WIDTH      = 4;
  localparam int ENTER_WIDTH          = 4;
  localparam int LEAVE_WIDTH          = 10;
  localparam int SHIFT_WIDTH          = 5;

  // configuration register indexes
  typedef enum logic [CFG_INDEX_WIDTH-1:0] {
    REG_IR_LOW     = 4'd0,
    REG_IR_HIGH    = 4'd1,
    REG_RED_LOW    = 4'd2,
    REG_RED_HIGH   = 4'd3,
    REG_SATURATION = 4'd4,
    REG_ENTER      = 4'd5,
    REG_LEAVE      = 4'd6,
    REG_SHIFT      = 4'd7
  } cfg_reg_t;

  // reset values, truncated to the sample width where used
  localparam int IR_LOW_RESET     = 50000;
  localparam int IR_HIGH_RESET    = 200000;
  localparam int RED_LOW_RESET    = 40000;
  localparam int RED_HIGH_RESET   = 180000;
  localparam int SATURATION_RESET = 260000;
  localparam int ENTER_RESET      = 3;
  localparam int LEAVE_RESET      = 500;
  localparam int SHIFT_RESET      = 5;

  // ratio and band scale factors
  localparam int RATIO_SCALE    = 10;
  localparam int STRICT_LO      = 5;
  localparam int STRICT_HI      = 12;
  localparam int TRACK_RATIO_LO = 3;
  localparam int TRACK_RATIO_HI = 15;
  localparam int BAND_SCALE     = 100;
  localparam int BAND_LO        = 25;
  localparam int BAND_HI        = 240;

  // headroom for products of a sample and a band factor
  localparam int PRODUCT_GROWTH = 8;

endpackage

// ===== rtl/ofpd_if.sv =====
// ---------------------------------------------------------------------------
// ofpd channel interfaces
// sample input, result output and configuration write channels
// ---------------------------------------------------------------------------
interface ofpd_sample_if
  import ofpd_pkg::*;
#(
  parameter int SAMPLE_WIDTH = SAMPLE_WIDTH_DEFAULT
);
  logic                    valid;
  logic                    ready;
  logic [SAMPLE_WIDTH-1:0] red_level;
  logic [SAMPLE_WIDTH-1:0] ir_level;

  modport source (output valid, output red_level, output ir_level, input ready);
  modport sink   (input valid, input red_level, input ir_level, output ready);
endinterface

interface ofpd_result_if;
  logic valid;
  logic ready;
  logic finger_present;
  logic sample_good;

  modport source (output valid, output finger_present, output sample_good, input ready);
  modport sink   (input valid, input finger_present, input sample_good, output ready);
endinterface

interface ofpd_cfg_if
  import ofpd_pkg::*;
#(
  parameter int SAMPLE_WIDTH = SAMPLE_WIDTH_DEFAULT
);
  logic                       valid;
  logic                       ready;
  logic [CFG_INDEX_WIDTH-1:0] index;
  logic [SAMPLE_WIDTH-1:0]    data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

// ===== rtl/optical_finger_presence_detector.sv =====
// ---------------------------------------------------------------------------
// optical_finger_presence_detector
// red/ir sample pair in, finger presence and sample quality out
// ---------------------------------------------------------------------------
//
//  channel   direction  payload                        transfer when
//  samples   in         red_level, ir_level            valid && ready
//  results   out        finger_present, sample_good    valid && ready
//  cfg       in         index, data                    valid && ready
//
//  one sample per cycle while results are taken; its result is registered in
//  the output register in the cycle after the input transfer, set by the single compare/update pass
//  that closes the state loop (counters, presence flag, references)
//  rst is synchronous and active high; config returns to its defaults
//  samples.ready is low only while a result is held and results.ready is
//  low; a result taken in the same cycle frees the register for the next
//  cfg.ready is always high
//
module optical_finger_presence_detector
  import ofpd_pkg::*;
#(
  parameter int SAMPLE_WIDTH = SAMPLE_WIDTH_DEFAULT
) (
  input  logic           clk,
  input  logic           rst,
  ofpd_sample_if.sink    samples,
  ofpd_result_if.source  results,
  ofpd_cfg_if.sink       cfg
);

`include "optical_finger_presence_detector_macros.svh"

  localparam int PW = SAMPLE_WIDTH + PRODUCT_GROWTH;

  typedef logic [SAMPLE_WIDTH-1:0] sample_t;
  typedef logic [PW-1:0]           product_t;

  // configuration registers
  sample_t                ir_low_limit;
  sample_t                ir_high_limit;
  sample_t                red_low_limit;
  sample_t                red_high_limit;
  sample_t                saturation_level;
  logic [ENTER_WIDTH-1:0] enter_frames;
  logic [LEAVE_WIDTH-1:0] leave_frames;
  logic [SHIFT_WIDTH-1:0] filter_shift;

  // detector state
  logic [ENTER_WIDTH-1:0] pass_count, pass_count_next;
  logic [LEAVE_WIDTH-1:0] fail_count, fail_count_next;
  logic                   present_flag, present_flag_next;
  sample_t                red_reference, red_reference_next;
  sample_t                ir_reference, ir_reference_next;

  // output register
  logic out_valid;
  logic out_present;
  logic out_quality;

  logic    in_xfer;
  sample_t red, ir;
  logic    strict, tracking, passed;

  // strict- and tracking-test products
  product_t red_x10, ir_x5, ir_x12, ir_x3, ir_x15;
  product_t red_x100, ir_x100;
  product_t red_ref_x25, red_ref_x240, ir_ref_x25, ir_ref_x240;

  // reference moves
  sample_t red_moved, ir_moved;

  assign cfg.ready     = 1'b1;
  assign samples.ready = !out_valid || results.ready;
  assign in_xfer       = samples.valid && samples.ready;

  assign results.valid          = out_valid;
  assign results.finger_present = out_present;
  assign results.sample_good    = out_quality;

  assign red = samples.red_level;
  assign ir  = samples.ir_level;

  // constant-factor products
  assign red_x10      = PW'(red) * PW'(RATIO_SCALE);
  assign ir_x5        = PW'(ir) * PW'(STRICT_LO);
  assign ir_x12       = PW'(ir) * PW'(STRICT_HI);
  assign ir_x3        = PW'(ir) * PW'(TRACK_RATIO_LO);
  assign ir_x15       = PW'(ir) * PW'(TRACK_RATIO_HI);
  assign red_x100     = PW'(red) * PW'(BAND_SCALE);
  assign ir_x100      = PW'(ir) * PW'(BAND_SCALE);
  assign red_ref_x25  = PW'(red_reference) * PW'(BAND_LO);
  assign red_ref_x240 = PW'(red_reference) * PW'(BAND_HI);
  assign ir_ref_x25   = PW'(ir_reference) * PW'(BAND_LO);
  assign ir_ref_x240  = PW'(ir_reference) * PW'(BAND_HI);

  // strict test: fixed windows and a ratio of 0.5 to 1.2
  assign strict = (ir >= ir_low_limit) && (ir <= ir_high_limit) &&
                  (red >= red_low_limit) && (red <= red_high_limit) &&
                  (red_x10 >= ir_x5) && (red_x10 <= ir_x12);

  // tracking test: present, live reference, unsaturated, 25..240 percent
  // of the reference and a ratio of 0.3 to 1.5
  assign tracking = present_flag &&
                    (red_reference != '0) && (ir_reference != '0) &&
                    (red < saturation_level) && (ir < saturation_level) &&
                    (red_x100 >= red_ref_x25) && (red_x100 <= red_ref_x240) &&
                    (ir_x100 >= ir_ref_x25) && (ir_x100 <= ir_ref_x240) &&
                    (red_x10 >= ir_x3) && (red_x10 <= ir_x15);

  assign passed = strict || tracking;

  // step each reference toward the sample; big shifts leave it unchanged
  always_comb begin
    if (red >= red_reference) begin
      red_moved = red_reference + ((red - red_reference) >> filter_shift);
    end else begin
      red_moved = red_reference - ((red_reference - red) >> filter_shift);
    end
    if (ir >= ir_reference) begin
      ir_moved = ir_reference + ((ir - ir_reference) >> filter_shift);
    end else begin
      ir_moved = ir_reference - ((ir_reference - ir) >> filter_shift);
    end
  end

  // presence state update
  always_comb begin
    pass_count_next    = pass_count;
    fail_count_next    = fail_count;
    present_flag_next  = present_flag;
    red_reference_next = red_reference;
    ir_reference_next  = ir_reference;
    if (passed) begin
      fail_count_next = '0;
      if (!present_flag) begin
        // counts up to enter_frames and stops there
        if (pass_count < enter_frames) begin
          pass_count_next = pass_count + 1'b1;
        end
        if (pass_count_next >= enter_frames) begin
          present_flag_next  = 1'b1;
          red_reference_next = red;
          ir_reference_next  = ir;
        end
      end else if (strict) begin
        red_reference_next = red_moved;
        ir_reference_next  = ir_moved;
      end
    end else begin
      pass_count_next = '0;
      if (fail_count < leave_frames) begin
        fail_count_next = fail_count + 1'b1;
      end
      // exit also applies when already absent
      if (fail_count_next >= leave_frames) begin
        present_flag_next  = 1'b0;
        red_reference_next = '0;
        ir_reference_next  = '0;
      end
    end
  end

  // configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      ir_low_limit     <= SAMPLE_WIDTH'(IR_LOW_RESET);
      ir_high_limit    <= SAMPLE_WIDTH'(IR_HIGH_RESET);
      red_low_limit    <= SAMPLE_WIDTH'(RED_LOW_RESET);
      red_high_limit   <= SAMPLE_WIDTH'(RED_HIGH_RESET);
      saturation_level <= SAMPLE_WIDTH'(SATURATION_RESET);
      enter_frames     <= ENTER_WIDTH'(ENTER_RESET);
      leave_frames     <= LEAVE_WIDTH'(LEAVE_RESET);
      filter_shift     <= SHIFT_WIDTH'(SHIFT_RESET);
    end else if (cfg.valid && cfg.ready) begin
      unique case (cfg.index)
        REG_IR_LOW:     ir_low_limit     <= cfg.data;
        REG_IR_HIGH:    ir_high_limit    <= cfg.data;
        REG_RED_LOW:    red_low_limit    <= cfg.data;
        REG_RED_HIGH:   red_high_limit   <= cfg.data;
        REG_SATURATION: saturation_level <= cfg.data;
        REG_ENTER:      enter_frames     <= cfg.data[ENTER_WIDTH-1:0];
        REG_LEAVE:      leave_frames     <= cfg.data[LEAVE_WIDTH-1:0];
        REG_SHIFT:      filter_shift     <= cfg.data[SHIFT_WIDTH-1:0];
        default: begin
          // indexes past the register list are dropped
        end
      endcase
    end
  end

  // detector state, advanced once per input transfer
  always_ff @(posedge clk) begin
    if (rst) begin
      pass_count    <= '0;
      fail_count    <= '0;
      present_flag  <= 1'b0;
      red_reference <= '0;
      ir_reference  <= '0;
    end else if (in_xfer) begin
      pass_count    <= pass_count_next;
      fail_count    <= fail_count_next;
      present_flag  <= present_flag_next;
      red_reference <= red_reference_next;
      ir_reference  <= ir_reference_next;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_xfer) begin
      out_valid <= 1'b1;
    end else if (results.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_xfer) begin
      out_present <= present_flag_next;
      out_quality <= present_flag_next && passed;
    end
  end

  // a good sample is only reported with a finger present
  `OFPD_ASSERT_NOW(a_quality_needs_presence, clk, rst, out_valid, !out_quality || out_present)
  // with no finger both references sit at zero
  `OFPD_ASSERT_NOW(a_absent_refs_zero, clk, rst, !present_flag,
    (red_reference == '0) && (ir_reference == '0))
  // a pass clears the fail run and a failure clears the pass run
  `OFPD_ASSERT_NOW(a_runs_exclusive, clk, rst, fail_count != '0, pass_count == '0)
  // every input transfer leaves a result in the output register
  `OFPD_ASSERT_NEXT(a_result_follows, clk, rst, in_xfer, out_valid)
  // the reported presence matches the flag it was taken from
  `OFPD_ASSERT_NEXT(a_present_tracks_flag, clk, rst, in_xfer, out_present == present_flag)

endmodule
